/* rtl/square_wave_harmonic_synth_macros.svh */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_HARMONIC_SYNTH_MACROS_SVH
`define SQUARE_WAVE_HARMONIC_SYNTH_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define SWHS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swhs assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SWHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swhs assertion failed");

`endif

/* rtl/swhs_pkg.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer package
// Formats, register indexes, microcode fields, the microcode program and the
// sine table generator.
// ----------------------------------------------------------------------------
package swhs_pkg;

  localparam int DEF_MAX_HARMONICS   = 64;
  localparam int DEF_SINE_TABLE_BITS = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd1;

  localparam int COUNT_W = 7;
  localparam logic [31:0]        FREQ_RESET  = 32'h0001_0000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd20;

  localparam int SINE_W  = 16;
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] FOUR_OVER_PI_Q16 = 17'd83443;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MULT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOOP   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SCALE  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd7;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_NO_START = 2'd1,
    COND_N_ZERO   = 2'd2,
    COND_MORE     = 2'd3
  } cond_t;

  typedef enum logic [1:0] {
    MUL_OFF   = 2'd0,
    MUL_FT    = 2'd1,
    MUL_TERM  = 2'd2,
    MUL_SCALE = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [STEP_W-1:0] target;
    cond_t             cond;
    logic              ld_in;
    logic              ld_phase;
    logic              issue;
    mul_sel_t          mul_sel;
    logic              emit;
  } uword_t;

  typedef struct packed {
    logic n_zero;
    logic more;
  } status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{target: STEP_IDLE, cond: COND_NO_START, ld_in: 1'b1, ld_phase: 1'b0,
          issue: 1'b0, mul_sel: MUL_OFF, emit: 1'b0};
    case (step)
      STEP_IDLE: begin
        w.target = STEP_IDLE;
      end
      STEP_MULT: begin
        w = '{target: STEP_LOAD, cond: COND_ALWAYS, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b0, mul_sel: MUL_FT, emit: 1'b0};
      end
      STEP_LOAD: begin
        w = '{target: STEP_SCALE, cond: COND_N_ZERO, ld_in: 1'b0, ld_phase: 1'b1,
              issue: 1'b0, mul_sel: MUL_OFF, emit: 1'b0};
      end
      STEP_LOOP: begin
        w = '{target: STEP_LOOP, cond: COND_MORE, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b1, mul_sel: MUL_TERM, emit: 1'b0};
      end
      STEP_DRAIN1: begin
        w = '{target: STEP_DRAIN2, cond: COND_ALWAYS, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b0, mul_sel: MUL_TERM, emit: 1'b0};
      end
      STEP_DRAIN2: begin
        w = '{target: STEP_SCALE, cond: COND_ALWAYS, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b0, mul_sel: MUL_OFF, emit: 1'b0};
      end
      STEP_SCALE: begin
        w = '{target: STEP_EMIT, cond: COND_ALWAYS, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b0, mul_sel: MUL_SCALE, emit: 1'b0};
      end
      STEP_EMIT: begin
        w = '{target: STEP_IDLE, cond: COND_ALWAYS, ld_in: 1'b0, ld_phase: 1'b0,
              issue: 1'b0, mul_sel: MUL_OFF, emit: 1'b1};
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Taylor series of sin to the x^11 term in Q30, rounded to Q1.15.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned idx,
                                                     input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(idx) * HALF_PI_Q30) >> (tbits - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

/* rtl/square_wave_harmonic_synth.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer
// Band-limited square wave from a partial sum of odd sine harmonics.
// ----------------------------------------------------------------------------
// A sample beat is taken on in_sample_time when start is high and busy is low.
// The result appears on out_wave_value for one cycle with out_valid high; the
// receiver cannot stall it and must take it in that cycle.
// The cfg port writes frequency_hz_q16 at index 0 and harmonic_count at index 1
// with cfg_we; other indexes are ignored. Write only while busy is low.
// With n the harmonic count, limited to MAX_HARMONICS, the sequencer steps
// through MULT, LOAD, a LOOP step per harmonic, DRAIN1, DRAIN2, SCALE and EMIT
// (LOAD jumps to SCALE when n is zero); out_valid is registered from EMIT, and
// the next sample can be taken in the cycle that out_valid is high. The loop
// issues one sine and reciprocal table read per cycle into the shared multiplier.
// Synchronous reset returns the sequencer to idle, drops any sample in flight
// and restores the configuration to 1.0 Hz and 20 harmonics.
// ----------------------------------------------------------------------------
module square_wave_harmonic_synth #(
  parameter int MAX_HARMONICS   = swhs_pkg::DEF_MAX_HARMONICS,
  parameter int SINE_TABLE_BITS = swhs_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     in_sample_time,
  output logic                            out_valid,
  output logic signed [15:0]              out_wave_value,
  input  logic                            cfg_we,
  input  logic [swhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swhs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RIDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

  swhs_pkg::uword_t                 uw;
  swhs_pkg::status_t                status;
  logic [SINE_TABLE_BITS-1:0]       phase_idx;
  logic [RIDX_W-1:0]                k_idx;
  logic signed [swhs_pkg::SINE_W:0] sine;
  logic [swhs_pkg::RECIP_W-1:0]     recip;

  swhs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .uw     (uw),
    .busy   (busy)
  );

  swhs_rom #(
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk       (clk),
    .rd_en     (uw.issue),
    .phase_idx (phase_idx),
    .k_idx     (k_idx),
    .sine      (sine),
    .recip     (recip)
  );

  swhs_dp #(
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .uw             (uw),
    .start          (start),
    .in_sample_time (in_sample_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sine           (sine),
    .recip          (recip),
    .phase_idx      (phase_idx),
    .k_idx          (k_idx),
    .status         (status),
    .out_valid      (out_valid),
    .out_wave_value (out_wave_value)
  );

endmodule

/* rtl/swhs_rom.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer tables
// Quarter-wave sine table with quadrant folding and odd reciprocal table,
// both with registered reads.
// ----------------------------------------------------------------------------
module swhs_rom #(
  parameter int MAX_HARMONICS   = swhs_pkg::DEF_MAX_HARMONICS,
  parameter int SINE_TABLE_BITS = swhs_pkg::DEF_SINE_TABLE_BITS,
  localparam int RIDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [SINE_TABLE_BITS-1:0]         phase_idx,
  input  logic [RIDX_W-1:0]                  k_idx,
  output logic signed [swhs_pkg::SINE_W:0]   sine,
  output logic [swhs_pkg::RECIP_W-1:0]       recip
);

  localparam int QLEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int QA_W = SINE_TABLE_BITS - 1;

  logic [swhs_pkg::SINE_W-1:0]  qtab [QLEN+1];
  logic [swhs_pkg::RECIP_W-1:0] rtab [MAX_HARMONICS];

  logic [1:0]                    quad;
  logic [SINE_TABLE_BITS-3:0]    j;
  logic [QA_W-1:0]               qaddr;
  logic [swhs_pkg::SINE_W-1:0]   qv_r;
  logic                          neg_r;
  logic [swhs_pkg::RECIP_W-1:0]  rec_r;
  logic signed [swhs_pkg::SINE_W:0] qs;

  for (genvar g = 0; g <= QLEN; g++) begin : g_qtab
    assign qtab[g] = swhs_pkg::quarter_sine(g, SINE_TABLE_BITS);
  end

  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_rtab
    localparam int unsigned D = 2 * g + 1;
    localparam int unsigned R = (131072 + D) / (2 * D);
    assign rtab[g] = swhs_pkg::RECIP_W'(R);
  end

  assign quad  = phase_idx[SINE_TABLE_BITS-1 -: 2];
  assign j     = phase_idx[SINE_TABLE_BITS-3:0];
  assign qaddr = quad[0] ? (QA_W'(QLEN) - {1'b0, j}) : {1'b0, j};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      qv_r  <= qtab[qaddr];
      neg_r <= quad[1];
      rec_r <= rtab[k_idx];
    end
  end

  assign qs    = signed'({1'b0, qv_r});
  assign sine  = neg_r ? -qs : qs;
  assign recip = rec_r;

endmodule

/* rtl/swhs_seq.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer sequencer
// Step counter over the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
module swhs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  swhs_pkg::status_t status,
  output swhs_pkg::uword_t  uw,
  output logic              busy
);

  logic [swhs_pkg::STEP_W-1:0] pc_r;
  logic [swhs_pkg::STEP_W-1:0] pc_nxt;
  logic                        taken;

  always_comb begin
    uw = swhs_pkg::ucode(pc_r);
    case (uw.cond)
      swhs_pkg::COND_ALWAYS:   taken = 1'b1;
      swhs_pkg::COND_NO_START: taken = !start;
      swhs_pkg::COND_N_ZERO:   taken = status.n_zero;
      swhs_pkg::COND_MORE:     taken = status.more;
      default:                 taken = 1'b0;
    endcase
    pc_nxt = taken ? uw.target : (pc_r + swhs_pkg::STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= swhs_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy = (pc_r != swhs_pkg::STEP_IDLE);

endmodule

/* rtl/swhs_dp.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer datapath
// Configuration registers, phase stepping, shared multiplier, accumulator
// and output rounding with saturation.
// ----------------------------------------------------------------------------
module swhs_dp #(
  parameter int MAX_HARMONICS   = swhs_pkg::DEF_MAX_HARMONICS,
  parameter int SINE_TABLE_BITS = swhs_pkg::DEF_SINE_TABLE_BITS,
  localparam int RIDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swhs_pkg::uword_t                   uw,
  input  logic                               start,
  input  logic [31:0]                        in_sample_time,
  input  logic                               cfg_we,
  input  logic [swhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swhs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [swhs_pkg::SINE_W:0]   sine,
  input  logic [swhs_pkg::RECIP_W-1:0]       recip,
  output logic [SINE_TABLE_BITS-1:0]         phase_idx,
  output logic [RIDX_W-1:0]                  k_idx,
  output swhs_pkg::status_t                  status,
  output logic                               out_valid,
  output logic signed [15:0]                 out_wave_value
);

  localparam int CNT_W = $clog2(MAX_HARMONICS + 1);
  localparam int CMP_W = (CNT_W > swhs_pkg::COUNT_W) ? CNT_W : swhs_pkg::COUNT_W;

  logic [31:0]                  freq_r;
  logic [swhs_pkg::COUNT_W-1:0] count_r;
  logic [31:0]                  time_r;
  logic [CNT_W-1:0]             n_r;
  logic [CNT_W-1:0]             n_nxt;
  logic [CNT_W-1:0]             k_r;
  logic [31:0]                  base_r;
  logic [31:0]                  phase_r;
  logic signed [65:0]           prod_r;
  logic signed [31:0]           acc_r;
  logic                         v1_r;
  logic                         v2_r;
  logic                         out_valid_r;
  logic signed [15:0]           out_wave_value_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [33:0] term_sum;
  logic signed [17:0] term_q;
  logic signed [49:0] sc_sum;
  logic signed [31:0] sc_q;
  logic signed [15:0] sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= swhs_pkg::FREQ_RESET;
      count_r <= swhs_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == swhs_pkg::CFG_FREQUENCY) begin
        freq_r <= cfg_data[31:0];
      end else if (cfg_index == swhs_pkg::CFG_COUNT) begin
        count_r <= cfg_data[swhs_pkg::COUNT_W-1:0];
      end
    end
  end

  assign n_nxt = (CMP_W'(count_r) > CMP_W'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS)
                                                           : CNT_W'(count_r);

  always_comb begin
    case (uw.mul_sel)
      swhs_pkg::MUL_FT: begin
        mul_a = {1'b0, freq_r};
        mul_b = {1'b0, time_r};
      end
      swhs_pkg::MUL_TERM: begin
        mul_a = {{16{sine[swhs_pkg::SINE_W]}}, sine};
        mul_b = {16'b0, recip};
      end
      swhs_pkg::MUL_SCALE: begin
        mul_a = {acc_r[31], acc_r};
        mul_b = {16'b0, swhs_pkg::FOUR_OVER_PI_Q16};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign term_sum = prod_r[33:0] + 34'sd32768;
  assign term_q   = term_sum[33:16];
  assign sc_sum   = prod_r[49:0] + 50'sd131072;
  assign sc_q     = sc_sum[49:18];

  always_comb begin
    if (sc_q > 32'sd32767) begin
      sat = 16'sh7fff;
    end else if (sc_q < -32'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sc_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (uw.ld_in && start) begin
      time_r <= in_sample_time;
      n_r    <= n_nxt;
    end
    if (uw.mul_sel != swhs_pkg::MUL_OFF) begin
      prod_r <= mul_p;
    end
    if (uw.ld_phase) begin
      base_r  <= prod_r[47:16];
      phase_r <= prod_r[47:16];
      k_r     <= '0;
      acc_r   <= '0;
    end else begin
      if (uw.issue) begin
        phase_r <= phase_r + {base_r[30:0], 1'b0};
        k_r     <= k_r + CNT_W'(1);
      end
      if (v2_r) begin
        acc_r <= acc_r + {{14{term_q[17]}}, term_q};
      end
    end
    if (uw.emit) begin
      out_wave_value_r <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= uw.issue;
      v2_r        <= v1_r;
      out_valid_r <= uw.emit;
    end
  end

  assign phase_idx      = phase_r[31 -: SINE_TABLE_BITS];
  assign k_idx          = k_r[RIDX_W-1:0];
  assign status.n_zero  = (n_r == '0);
  assign status.more    = ((k_r + CNT_W'(1)) != n_r);
  assign out_valid      = out_valid_r;
  assign out_wave_value = out_wave_value_r;

endmodule

/* rtl/swhs_checker.sv */
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer checker
// Port-level checks on the sample and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "square_wave_harmonic_synth_macros.svh"

module swhs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `SWHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SWHS_ASSERT_SAME(a_result_idle, out_valid, !busy)
  `SWHS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `SWHS_ASSERT_SAME(a_done_result, $fell(busy), out_valid)

endmodule

bind square_wave_harmonic_synth swhs_checker u_swhs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Square wave harmonic synthesizer testbench
// Drives sample beats under several frequency and harmonic count settings,
// predicts each wave value with an independent fixed-point model of the
// partial Fourier sum, and compares every result beat as it comes out.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUARTER_LEN = 256;
  localparam int MAX_HARM    = swhs_pkg::DEF_MAX_HARMONICS;
  localparam logic [swhs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [swhs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [31:0]                     in_sample_time;
  logic                            out_valid;
  logic signed [15:0]              out_wave_value;
  logic                            cfg_we;
  logic [swhs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swhs_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [31:0]        freq_q16;
  logic [6:0]         harm_count;
  logic signed [15:0] sine_quarter [0:QUARTER_LEN];
  logic [16:0]        recip_odd [0:MAX_HARM-1];
  logic signed [15:0] wave_expected [$];
  int                 error_count;
  bit                 idle_on;

  square_wave_harmonic_synth dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_wave_value (out_wave_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic signed [15:0] taylor_sine(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] one;
    logic [63:0] v;
    one = 64'd1 << 30;
    x   = (64'(idx) * 64'd1686629713) >> 8;
    x2  = (x * x) >> 30;
    acc = one - x2 / 64'd110;
    acc = one - ((x2 * acc) >> 30) / 64'd72;
    acc = one - ((x2 * acc) >> 30) / 64'd42;
    acc = one - ((x2 * acc) >> 30) / 64'd20;
    acc = one - ((x2 * acc) >> 30) / 64'd6;
    v   = (((x * acc) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint unsigned half;
    longint unsigned mag;
    half = 64'd1 << (s - 1);
    if (v >= 0) begin
      return $signed(($unsigned(v) + half) >> s);
    end
    mag = 64'd0 - $unsigned(v);
    return -$signed((mag + half - 64'd1) >> s);
  endfunction

  function automatic logic signed [15:0] odd_sine(input logic [31:0] phase);
    logic [9:0]         p;
    logic signed [15:0] v;
    p = phase[31:22];
    v = p[8] ? sine_quarter[QUARTER_LEN - p[7:0]] : sine_quarter[p[7:0]];
    return p[9] ? -v : v;
  endfunction

  function automatic logic signed [15:0] synth_wave(input logic [31:0] sample_t);
    logic [63:0] ft;
    logic [31:0] base;
    logic [63:0] ph;
    int          n;
    longint      acc;
    longint      y;
    ft  = 64'(freq_q16) * 64'(sample_t);
    base = ft[47:16];
    n   = (harm_count > MAX_HARM) ? MAX_HARM : int'(harm_count);
    acc = 0;
    for (int k = 0; k < n; k++) begin
      ph  = 64'(base) * 64'(2 * k + 1);
      acc += round_shift(longint'(odd_sine(ph[31:0])) * longint'(recip_odd[k]), 16);
    end
    y = round_shift(acc * longint'(swhs_pkg::FOUR_OVER_PI_Q16), 18);
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    return y[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_valid) begin
      if (wave_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %0d", out_wave_value));
      end else begin
        want = wave_expected.pop_front();
        if (out_wave_value !== want) begin
          report_mismatch($sformatf("wave_value %0d, expected %0d", out_wave_value, want));
        end
      end
    end
  end

  task automatic send_sample(input logic [31:0] sample_t);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_sample_time = sample_t;
    @(posedge clk);
    while (busy) @(posedge clk);
    wave_expected.push_back(synth_wave(sample_t));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (wave_expected.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == swhs_pkg::CFG_FREQUENCY) begin
      freq_q16 = data;
    end else if (idx == swhs_pkg::CFG_COUNT) begin
      harm_count = data[6:0];
    end
  endtask

  function automatic logic [31:0] pick_sample();
    int b;
    b = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << b;
      3: return ~(32'd1 << b);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'h0000_0000);
    send_sample(32'h4000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_zero_harmonics();
    write_reg(swhs_pkg::CFG_COUNT, 32'd0);
    send_sample(32'h4000_0000);
    send_sample(32'hC000_0000);
    wait_idle();
  endtask

  task automatic test_count_limits();
    write_reg(swhs_pkg::CFG_COUNT, 32'd1);
    send_sample(32'h4000_0000);
    send_sample(32'h2000_0000);
    wait_idle();
    write_reg(swhs_pkg::CFG_COUNT, 32'd64);
    send_sample(32'h4000_0000);
    send_sample(32'h0100_0000);
    wait_idle();
    write_reg(swhs_pkg::CFG_COUNT, 32'd65);
    send_sample(32'h0100_0000);
    wait_idle();
    write_reg(swhs_pkg::CFG_COUNT, 32'hFFFF_FFFF);
    send_sample(32'h3000_0000);
    wait_idle();
  endtask

  task automatic test_phase_wrap();
    write_reg(swhs_pkg::CFG_COUNT, 32'd20);
    write_reg(swhs_pkg::CFG_FREQUENCY, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h1234_5678);
    wait_idle();
    write_reg(swhs_pkg::CFG_FREQUENCY, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    wait_idle();
    write_reg(swhs_pkg::CFG_FREQUENCY, 32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE_A, 32'hDEAD_BEEF);
    write_reg(CFG_SPARE_B, 32'h0000_0000);
    send_sample(32'h2AAA_AAAA);
    send_sample(32'h5555_5555);
    wait_idle();
  endtask

  task automatic test_random_sweep();
    logic [31:0] freqs [4];
    logic [6:0]  counts [4];
    logic [31:0] fsel;
    logic [6:0]  csel;
    freqs  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, swhs_pkg::FREQ_RESET};
    counts = '{7'd64, 7'd0, 7'd127, 7'd1};
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph < 10);
      wait_idle();
      if (ph < 4) begin
        fsel = freqs[ph];
        csel = counts[ph];
      end else begin
        case ($urandom_range(0, 3))
          0: fsel = $urandom;
          1: fsel = $urandom_range(1, 20000) << 16;
          2: fsel = {16'd0, 16'($urandom)};
          default: fsel = freqs[$urandom_range(0, 3)];
        endcase
        csel = ($urandom_range(0, 3) == 0) ? counts[$urandom_range(0, 3)]
                                           : 7'($urandom_range(0, 127));
      end
      write_reg(swhs_pkg::CFG_FREQUENCY, fsel);
      write_reg(swhs_pkg::CFG_COUNT, {$urandom} << 7 | 32'(csel));
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      end
      for (int i = 0; i < 100; i++) begin
        send_sample(pick_sample());
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_sample_time = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    error_count    = 0;
    idle_on        = 1'b1;
    freq_q16       = swhs_pkg::FREQ_RESET;
    harm_count     = swhs_pkg::COUNT_RESET;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      sine_quarter[i] = taylor_sine(i);
    end
    for (int i = 0; i < MAX_HARM; i++) begin
      recip_odd[i] = 17'((131072 + 2 * i + 1) / (2 * (2 * i + 1)));
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_zero_harmonics();
    test_count_limits();
    test_phase_wrap();
    test_spare_index();
    test_random_sweep();

    repeat (80) @(posedge clk);
    if (wave_expected.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never came", wave_expected.size()));
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* square_wave_harmonic_synth.f */
+incdir+rtl
rtl/swhs_pkg.sv
rtl/swhs_rom.sv
rtl/swhs_seq.sv
rtl/swhs_dp.sv
rtl/square_wave_harmonic_synth.sv
rtl/swhs_checker.sv
verif/tb_top.sv
